[hw/rtl/bmp_to_rgb565_stream_core_macros.svh]
// Assertion macros for the BMP to RGB565 stream core.
// Uses the enclosing module's clk and rst_n; empty under synthesis.
`ifndef BMP_TO_RGB565_STREAM_CORE_MACROS_SVH
`define BMP_TO_RGB565_STREAM_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define B565_CHECK_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmp565 same-cycle check failed");
// Next-cycle implication, disabled during reset
`define B565_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmp565 next-cycle check failed");
`else
`define B565_CHECK_NOW(label, ante, cons)
`define B565_CHECK_NEXT(label, ante, cons)
`endif

`endif

[hw/rtl/bmp565_pkg.sv]
// Shared types and constants for the BMP to RGB565 stream core.
// No dependencies; used by the parser, the output queue and the top level.
package bmp565_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_DONE,
        PH_ERROR
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_SHORT     = 3'd1;
    localparam logic [2:0] ERR_SIGNATURE = 3'd2;
    localparam logic [2:0] ERR_DEPTH     = 3'd3;
    localparam logic [2:0] ERR_SIZE      = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_ORIGIN_X   = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Y   = 2'd1;
    localparam logic [1:0] CFG_REQ_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_REQ_HEIGHT = 2'd3;

    // Header layout
    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [31:0] HEADER_BYTES  = 32'd54;
    localparam logic [5:0]  HEADER_LAST   = 6'd53;
    localparam logic [5:0]  POS_SIG       = 6'd0;
    localparam logic [5:0]  POS_OFFSET    = 6'd10;
    localparam logic [5:0]  POS_WIDTH     = 6'd18;
    localparam logic [5:0]  POS_HEIGHT    = 6'd22;
    localparam logic [5:0]  POS_DEPTH     = 6'd28;
    localparam logic [15:0] BPP_24        = 16'd24;
    localparam logic [15:0] BPP_32        = 16'd32;

    typedef struct packed {
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [11:0] req_width;
        logic [11:0] req_height;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  err;
        logic [12:0] x;
        logic [12:0] y;
        logic [15:0] color;
        logic        last;
    } res_t;

    // Up to two results caused by one byte: a pixel and then an end marker
    typedef struct packed {
        logic first_vld;
        logic second_vld;
        res_t first;
        res_t second;
    } res_pair_t;

    function automatic logic [15:0] rgb565(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        rgb565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

    function automatic res_t end_result(input logic [1:0] kind, input logic [2:0] err);
        res_t r;
        r       = '0;
        r.kind  = kind;
        r.err   = err;
        r.last  = 1'b1;
        end_result = r;
    endfunction

endpackage

[hw/rtl/bmp565_parse.sv]
// Byte parser: header capture and check, skip to pixel data, BGR(A) to RGB565.
// Depends on bmp565_pkg; results leave as a combinational pair per accepted byte.
module bmp565_parse #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_file,
    input  bmp565_pkg::cfg_t       cfg,
    output bmp565_pkg::res_pair_t  pair
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = WW + 2;
    localparam int CW = (WW > 12) ? WW : 12;
    localparam int CH = (HW > 12) ? HW : 12;

    bmp565_pkg::phase_t phase_reg, phase_next;
    logic [31:0]   pos_reg, pos_next;
    logic [15:0]   sig_reg, sig_next;
    logic [31:0]   offset_reg, offset_next;
    logic [31:0]   width_raw_reg, width_raw_next;
    logic [31:0]   height_raw_reg, height_raw_next;
    logic [15:0]   bpp_reg, bpp_next;
    logic [HW-1:0] height_reg, height_next;
    logic [RW-1:0] rbc_reg, rbc_next;
    logic [HW-1:0] file_row_reg, file_row_next;
    logic [WW-1:0] column_reg, column_next;
    logic [RW-1:0] bir_reg, bir_next;
    logic [1:0]    bip_reg, bip_next;
    logic [7:0]    blue_reg, blue_next;
    logic [7:0]    green_reg, green_next;

    logic [5:0]    pos6;
    logic [31:0]   h_abs;
    logic          size_bad;
    logic [WW-1:0] width;
    logic [RW-1:0] rbc24;
    logic [1:0]    last_bip;
    logic [CW-1:0] w_eff;
    logic [CH-1:0] h_eff;
    logic [RW-1:0] bir_inc;
    logic [HW-1:0] row_inc;
    logic          pix_vld;
    logic          term_vld;
    bmp565_pkg::res_t pix_res;
    bmp565_pkg::res_t term_res;

    // Header checks and derived sizes
    assign pos6     = pos_reg[5:0];
    assign h_abs    = height_raw_reg[31] ? (~height_raw_reg + 32'd1) : height_raw_reg;
    assign size_bad = (width_raw_reg == 32'd0) || (width_raw_reg > 32'(MAX_WIDTH)) ||
                      (h_abs == 32'd0) || (h_abs > 32'(MAX_HEIGHT)) ||
                      (offset_reg < bmp565_pkg::HEADER_BYTES);
    assign width    = width_raw_reg[WW-1:0];
    assign rbc24    = (RW'({width, 1'b0}) + RW'(width) + RW'(3)) & ~RW'(3);
    assign last_bip = (bpp_reg == bmp565_pkg::BPP_32) ? 2'd3 : 2'd2;
    assign w_eff    = (cfg.req_width != 12'd0) ? CW'(cfg.req_width) : CW'(width);
    assign h_eff    = (cfg.req_height != 12'd0) ? CH'(cfg.req_height) : CH'(height_reg);
    assign bir_inc  = bir_reg + RW'(1);
    assign row_inc  = file_row_reg + HW'(1);

    // Next state and results for the byte at the input
    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        sig_next        = sig_reg;
        offset_next     = offset_reg;
        width_raw_next  = width_raw_reg;
        height_raw_next = height_raw_reg;
        bpp_next        = bpp_reg;
        height_next     = height_reg;
        rbc_next        = rbc_reg;
        file_row_next   = file_row_reg;
        column_next     = column_reg;
        bir_next        = bir_reg;
        bip_next        = bip_reg;
        blue_next       = blue_reg;
        green_next      = green_reg;
        pix_vld         = 1'b0;
        pix_res         = '0;
        term_vld        = 1'b0;
        term_res        = '0;

        if (accept && phase_reg != bmp565_pkg::PH_DONE &&
            phase_reg != bmp565_pkg::PH_ERROR)
        begin
            unique case (phase_reg)
                bmp565_pkg::PH_HEADER:
                begin
                    // Capture header fields, little-endian
                    if (pos6 < bmp565_pkg::POS_SIG + 6'd2)
                    begin
                        sig_next[{pos6[0], 3'b000} +: 8] = data_byte;
                    end
                    else if (pos6 >= bmp565_pkg::POS_OFFSET && pos6 < bmp565_pkg::POS_OFFSET + 6'd4)
                    begin
                        offset_next[{2'(pos6 - bmp565_pkg::POS_OFFSET), 3'b000} +: 8] = data_byte;
                    end
                    else if (pos6 >= bmp565_pkg::POS_WIDTH && pos6 < bmp565_pkg::POS_WIDTH + 6'd4)
                    begin
                        width_raw_next[{2'(pos6 - bmp565_pkg::POS_WIDTH), 3'b000} +: 8] =
                            data_byte;
                    end
                    else if (pos6 >= bmp565_pkg::POS_HEIGHT &&
                             pos6 < bmp565_pkg::POS_HEIGHT + 6'd4)
                    begin
                        height_raw_next[{2'(pos6 - bmp565_pkg::POS_HEIGHT), 3'b000} +: 8] =
                            data_byte;
                    end
                    else if (pos6 >= bmp565_pkg::POS_DEPTH && pos6 < bmp565_pkg::POS_DEPTH + 6'd2)
                    begin
                        bpp_next[{1'(pos6 - bmp565_pkg::POS_DEPTH), 3'b000} +: 8] = data_byte;
                    end

                    // Check the header on its last byte
                    if (pos6 == bmp565_pkg::HEADER_LAST)
                    begin
                        priority if (sig_reg != bmp565_pkg::BMP_SIGNATURE)
                        begin
                            phase_next = bmp565_pkg::PH_ERROR;
                            term_vld   = 1'b1;
                            term_res   = bmp565_pkg::end_result(bmp565_pkg::KIND_ERROR,
                                                                bmp565_pkg::ERR_SIGNATURE);
                        end
                        else if (bpp_reg != bmp565_pkg::BPP_24 && bpp_reg != bmp565_pkg::BPP_32)
                        begin
                            phase_next = bmp565_pkg::PH_ERROR;
                            term_vld   = 1'b1;
                            term_res   = bmp565_pkg::end_result(bmp565_pkg::KIND_ERROR,
                                                                bmp565_pkg::ERR_DEPTH);
                        end
                        else if (size_bad)
                        begin
                            phase_next = bmp565_pkg::PH_ERROR;
                            term_vld   = 1'b1;
                            term_res   = bmp565_pkg::end_result(bmp565_pkg::KIND_ERROR,
                                                                bmp565_pkg::ERR_SIZE);
                        end
                        else
                        begin
                            height_next = HW'(h_abs);
                            rbc_next    = (bpp_reg == bmp565_pkg::BPP_32) ?
                                          RW'({width, 2'b00}) : rbc24;
                            phase_next  = (offset_reg == bmp565_pkg::HEADER_BYTES) ?
                                          bmp565_pkg::PH_PIXELS : bmp565_pkg::PH_SKIP;
                        end
                    end
                end

                bmp565_pkg::PH_SKIP:
                begin
                    // Advance to pixel data after the byte just before the offset
                    if ({1'b0, pos_reg} + 33'd1 == {1'b0, offset_reg})
                    begin
                        phase_next = bmp565_pkg::PH_PIXELS;
                    end
                end

                bmp565_pkg::PH_PIXELS:
                begin
                    // Assemble the pixel; padding bytes past the last column only count
                    if (column_reg < width)
                    begin
                        unique case (bip_reg)
                            2'd0: blue_next  = data_byte;
                            2'd1: green_next = data_byte;
                            2'd2:
                            begin
                                if (CW'(column_reg) < w_eff && CH'(file_row_reg) < h_eff)
                                begin
                                    pix_vld       = 1'b1;
                                    pix_res.kind  = bmp565_pkg::KIND_PIXEL;
                                    pix_res.err   = bmp565_pkg::ERR_NONE;
                                    pix_res.x     = {cfg.origin_x[11], cfg.origin_x} +
                                                    13'(column_reg);
                                    pix_res.y     = {cfg.origin_y[11], cfg.origin_y} +
                                                    13'(h_eff) - 13'd1 - 13'(file_row_reg);
                                    pix_res.color = bmp565_pkg::rgb565(data_byte, green_reg,
                                                                       blue_reg);
                                end
                            end
                            default: ;
                        endcase
                        if (bip_reg >= last_bip)
                        begin
                            column_next = column_reg + WW'(1);
                            bip_next    = 2'd0;
                        end
                        else
                        begin
                            bip_next = bip_reg + 2'd1;
                        end
                    end

                    // Close the row at the end of its padding
                    bir_next = bir_inc;
                    if (bir_inc >= rbc_reg)
                    begin
                        bir_next      = '0;
                        column_next   = '0;
                        bip_next      = 2'd0;
                        file_row_next = row_inc;
                        if (row_inc >= height_reg)
                        begin
                            phase_next = bmp565_pkg::PH_DONE;
                            term_vld   = 1'b1;
                            term_res   = bmp565_pkg::end_result(bmp565_pkg::KIND_FINISH,
                                                                bmp565_pkg::ERR_NONE);
                        end
                    end
                end

                default: ;
            endcase

            // Saturate the byte count
            if (pos_reg != 32'hFFFF_FFFF)
            begin
                pos_next = pos_reg + 32'd1;
            end

            // File ended before the image did
            if (end_of_file && phase_next != bmp565_pkg::PH_DONE &&
                phase_next != bmp565_pkg::PH_ERROR)
            begin
                phase_next = bmp565_pkg::PH_ERROR;
                term_vld   = 1'b1;
                term_res   = bmp565_pkg::end_result(bmp565_pkg::KIND_ERROR,
                                                    bmp565_pkg::ERR_SHORT);
            end
        end

        // Order the results: pixel first, end marker last
        pair.first_vld  = pix_vld | term_vld;
        pair.second_vld = pix_vld & term_vld;
        pair.first      = pix_vld ? pix_res : term_res;
        pair.first.last = ~(pix_vld & term_vld);
        pair.second     = term_res;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= bmp565_pkg::PH_HEADER;
            pos_reg        <= '0;
            sig_reg        <= '0;
            offset_reg     <= '0;
            width_raw_reg  <= '0;
            height_raw_reg <= '0;
            bpp_reg        <= '0;
            height_reg     <= '0;
            rbc_reg        <= '0;
            file_row_reg   <= '0;
            column_reg     <= '0;
            bir_reg        <= '0;
            bip_reg        <= '0;
            blue_reg       <= '0;
            green_reg      <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            sig_reg        <= sig_next;
            offset_reg     <= offset_next;
            width_raw_reg  <= width_raw_next;
            height_raw_reg <= height_raw_next;
            bpp_reg        <= bpp_next;
            height_reg     <= height_next;
            rbc_reg        <= rbc_next;
            file_row_reg   <= file_row_next;
            column_reg     <= column_next;
            bir_reg        <= bir_next;
            bip_reg        <= bip_next;
            blue_reg       <= blue_next;
            green_reg      <= green_next;
        end
    end

endmodule

[hw/rtl/bmp565_outq.sv]
// Two-slot result register: the head drives the output stream, the second
// slot holds an end marker that follows a pixel. Depends on bmp565_pkg.
module bmp565_outq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  bmp565_pkg::res_pair_t pair,
    output logic                  space,
    output logic                  out_valid,
    input  logic                  out_ready,
    output bmp565_pkg::res_t      out_res
);

    logic             a_vld_reg, a_vld_next;
    logic             b_vld_reg, b_vld_next;
    bmp565_pkg::res_t a_reg, a_next;
    bmp565_pkg::res_t b_reg, b_next;
    logic             pop;

    // Take a new item only when both slots will be free
    assign pop       = a_vld_reg & out_ready;
    assign space     = ~b_vld_reg & (~a_vld_reg | out_ready);
    assign out_valid = a_vld_reg;
    assign out_res   = a_reg;

    // Load on accept, otherwise advance the second slot on a pop
    always_comb
    begin
        a_vld_next = a_vld_reg;
        b_vld_next = b_vld_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        if (accept)
        begin
            a_vld_next = pair.first_vld | (a_vld_reg & ~pop);
            b_vld_next = pair.second_vld;
            if (pair.first_vld)
            begin
                a_next = pair.first;
                b_next = pair.second;
            end
        end
        else if (pop)
        begin
            a_vld_next = b_vld_reg;
            b_vld_next = 1'b0;
            a_next     = b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= a_vld_next;
            b_vld_reg <= b_vld_next;
        end
    end

    // Hold payload, no reset
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

endmodule

[hw/rtl/bmp_to_rgb565_stream_core.sv]
// BMP to RGB565 stream core: one file byte per cycle in, RGB565 pixels out.
// The first result of an accepted byte is registered and on the output in the next cycle.
// Throughput: one byte per cycle; a byte causing a pixel and an end marker holds s_tready
// low until the end marker leaves the second slot, and s_tready follows m_tready through the
// two result slots. Reset (rst_n low, asynchronous) returns to the header phase, zeroes the
// parser and configuration registers, and empties the output.
`include "bmp_to_rgb565_stream_core_macros.svh"

module bmp_to_rgb565_stream_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_file
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [2:0] error_code, [15:3] pixel_x, [28:16] pixel_y,
                                   // [44:29] pixel_color, [47:45] zero
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast,   // last_result
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    bmp565_pkg::cfg_t      cfg_reg;
    bmp565_pkg::res_pair_t pair;
    bmp565_pkg::res_t      out_res;
    logic                  s_accept;
    logic                  space;
    logic                  is_pixel;

    assign s_tready = space;
    assign s_accept = s_tvalid & space;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bmp565_pkg::CFG_ORIGIN_X:   cfg_reg.origin_x   <= cfg_data;
                bmp565_pkg::CFG_ORIGIN_Y:   cfg_reg.origin_y   <= cfg_data;
                bmp565_pkg::CFG_REQ_WIDTH:  cfg_reg.req_width  <= cfg_data;
                bmp565_pkg::CFG_REQ_HEIGHT: cfg_reg.req_height <= cfg_data;
            endcase
        end
    end

    bmp565_parse #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (s_accept),
        .data_byte   (s_tdata),
        .end_of_file (s_tlast),
        .cfg         (cfg_reg),
        .pair        (pair)
    );

    bmp565_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (s_accept),
        .pair      (pair),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the result item
    assign m_tdata  = {3'b000, out_res.color, out_res.y, out_res.x, out_res.err};
    assign m_tuser  = out_res.kind;
    assign m_tlast  = out_res.last;
    assign is_pixel = (m_tuser == bmp565_pkg::KIND_PIXEL);

    // An end marker is always the final result of its byte
    `B565_CHECK_NOW(end_is_last, m_tvalid && !is_pixel, m_tlast)
    // Pixels carry no error code
    `B565_CHECK_NOW(pixel_no_err, m_tvalid && is_pixel, m_tdata[2:0] == bmp565_pkg::ERR_NONE)
    // Nothing follows a delivered end marker
    `B565_CHECK_NEXT(quiet_after_end, m_tvalid && m_tready && !is_pixel, !m_tvalid)

endmodule
